FILE: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console cell writer: request and
// result payloads, character codes and the controller state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // request payload
  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [7:0] target_col;
    logic [7:0] target_row;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic [6:0] out_column;
    logic [4:0] out_row;
    logic [7:0] cell_char;
    logic       screen_cleared;
  } out_rsp_t;

  // request function codes
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_POS = 1'b1;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // tab stops every four columns
  localparam logic [2:0] TAB_STOP = 3'd4;

  // attribute after reset
  localparam logic [7:0] RESET_COLOR = 8'd7;

  // controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_POS_MOD,
    S_POS_RD,
    S_POS_DATA,
    S_GLYPH,
    S_CLEAR,
    S_RESULT
  } state_e;

endpackage

FILE: src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tcw_mod.sv
// ----------------------------------------------------------------------------
// tcw_mod
// Remainder of an 8-bit value by a constant divisor. The quotient comes from
// a registered multiply by the rounded-up reciprocal; the remainder follows
// in the cycle after the value is presented.
// ----------------------------------------------------------------------------
module tcw_mod #(
  parameter int unsigned DIVISOR = 80,
  localparam int unsigned RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic          clk_i,
  input  logic [7:0]    val_i,
  output logic [RW-1:0] rem_o
);

  // ceil(2^16 / DIVISOR), exact for all 8-bit dividends
  localparam logic [23:0] RECIP = 24'((65536 + DIVISOR - 1) / DIVISOR);
  localparam logic [15:0] DIV_W = 16'(DIVISOR);

  logic [7:0]  val_q;
  logic [23:0] prod_q;
  logic [15:0] rem_raw;
  logic [15:0] rem_fix;

  // reciprocal product
  always_ff @(posedge clk_i) begin
    val_q  <= val_i;
    prod_q <= {16'd0, val_i} * RECIP;
  end

  // remainder with a final range fix
  always_comb begin
    rem_raw = {8'd0, val_q} - ({8'd0, prod_q[23:16]} * DIV_W);
    rem_fix = (rem_raw >= DIV_W) ? (rem_raw - DIV_W) : rem_raw;
  end

  assign rem_o = rem_fix[RW-1:0];

endmodule

FILE: src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text screen of character/attribute cells with a cursor. Put requests write
// characters and move the cursor, set-position requests move the cursor and
// read back the character under it.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_data_i and are taken when in_stall_o is
//   low; one result leaves on out_valid_o/out_data_o per request and is held
//   while out_stall_i is high. cfg_we_i/cfg_data_i write the text color.
//   One request is in work at a time; in_stall_o is low only while idle.
//   Each request passes S_EXEC and S_RESULT. A printable character is written
//   in S_GLYPH; a tab writes spaces there up to the next tab stop, one cell
//   per cycle unless a clear sweep comes between; set position goes through
//   S_POS_MOD, S_POS_RD and S_POS_DATA. A request that runs the cursor off
//   the bottom sweeps every cell of the single-write-port cell memory to
//   spaces. After reset the same sweep fills the screen with spaces in color
//   7 while in_stall_o stays high.
//   A finished result waits in the output register while the receiver
//   stalls; the next request is accepted meanwhile, and its result is held
//   back until the output register is free.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int unsigned SCREEN_COLS = 80,
  parameter int unsigned SCREEN_ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcw_pkg::out_rsp_t out_data_o
);

  localparam int unsigned CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int unsigned RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(SCREEN_ROWS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLS);

  tcw_pkg::state_e   state_q, state_d;
  tcw_pkg::in_req_t  req_q;
  tcw_pkg::out_rsp_t out_data_q;
  logic              out_valid_q;

  logic [7:0]    color_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [AW-1:0] sweep_q;
  logic [2:0]    cnt_q;
  logic [7:0]    glyph_q;
  logic [7:0]    cell_char_q;
  logic          cleared_q;

  logic [CW-1:0] col_mod;
  logic [RW-1:0] row_mod;
  logic [AW-1:0] cur_addr;
  logic          col_last;
  logic          row_last;
  logic          sweep_last;
  logic          in_accept;
  logic          load_out;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign cur_addr   = (AW'(row_q) * COLS_A) + AW'(col_q);
  assign col_last   = (col_q == COL_LAST);
  assign row_last   = (row_q == ROW_LAST);
  assign sweep_last = (sweep_q == CELL_LAST);

  // cell store
  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(cur_addr),
    .rdata_o(mem_rdata)
  );

  // target position wrap
  tcw_mod #(.DIVISOR(SCREEN_COLS)) u_col_mod (
    .clk_i(clk_i),
    .val_i(req_q.target_col),
    .rem_o(col_mod)
  );

  tcw_mod #(.DIVISOR(SCREEN_ROWS)) u_row_mod (
    .clk_i(clk_i),
    .val_i(req_q.target_row),
    .rem_o(row_mod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::S_INIT: begin
        if (sweep_last) state_d = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        priority if (req_q.func == tcw_pkg::FUNC_POS) begin
          state_d = tcw_pkg::S_POS_MOD;
        end else if (req_q.char_code == tcw_pkg::CH_NUL ||
                     req_q.char_code == tcw_pkg::CH_RETURN) begin
          state_d = tcw_pkg::S_RESULT;
        end else if (req_q.char_code == tcw_pkg::CH_NEWLINE) begin
          state_d = row_last ? tcw_pkg::S_CLEAR : tcw_pkg::S_RESULT;
        end else begin
          state_d = tcw_pkg::S_GLYPH;
        end
      end
      tcw_pkg::S_POS_MOD:  state_d = tcw_pkg::S_POS_RD;
      tcw_pkg::S_POS_RD:   state_d = tcw_pkg::S_POS_DATA;
      tcw_pkg::S_POS_DATA: state_d = tcw_pkg::S_RESULT;
      tcw_pkg::S_GLYPH: begin
        priority if (col_last && row_last) state_d = tcw_pkg::S_CLEAR;
        else if (cnt_q == 3'd1) state_d = tcw_pkg::S_RESULT;
      end
      tcw_pkg::S_CLEAR: begin
        if (sweep_last) begin
          state_d = (cnt_q != 3'd0) ? tcw_pkg::S_GLYPH : tcw_pkg::S_RESULT;
        end
      end
      tcw_pkg::S_RESULT: begin
        if (!out_valid_q || !out_stall_i) state_d = tcw_pkg::S_IDLE;
      end
      default: state_d = tcw_pkg::S_INIT;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = {color_q, glyph_q};
    unique case (state_q)
      tcw_pkg::S_IDLE: in_stall_o = 1'b0;
      tcw_pkg::S_INIT, tcw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = {color_q, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::S_GLYPH: mem_we = 1'b1;
      tcw_pkg::S_RESULT: load_out = !out_valid_q || !out_stall_i;
      default: begin
      end
    endcase
  end

  // state register and text color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::S_INIT;
      color_q <= tcw_pkg::RESET_COLOR;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) color_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_accept) req_q <= in_data_i;
  end

  // cursor, sweep counter and per-request work registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      sweep_q     <= '0;
      cnt_q       <= '0;
      glyph_q     <= '0;
      cell_char_q <= '0;
      cleared_q   <= 1'b0;
    end else begin
      unique case (state_q)
        tcw_pkg::S_INIT, tcw_pkg::S_CLEAR: begin
          sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
        end
        tcw_pkg::S_EXEC: begin
          cell_char_q <= '0;
          cleared_q   <= 1'b0;
          cnt_q       <= 3'd1;
          glyph_q     <= req_q.char_code;
          if (req_q.func == tcw_pkg::FUNC_PUT) begin
            priority if (req_q.char_code == tcw_pkg::CH_RETURN) begin
              col_q <= '0;
            end else if (req_q.char_code == tcw_pkg::CH_NEWLINE) begin
              col_q     <= '0;
              row_q     <= row_last ? '0 : row_q + RW'(1);
              cleared_q <= row_last;
              cnt_q     <= 3'd0;
            end else if (req_q.char_code == tcw_pkg::CH_TAB) begin
              cnt_q   <= tcw_pkg::TAB_STOP - {1'b0, col_q[1:0]};
              glyph_q <= tcw_pkg::CH_SPACE;
            end
          end
        end
        tcw_pkg::S_POS_MOD: begin
          col_q <= col_mod;
          row_q <= row_mod;
        end
        tcw_pkg::S_POS_DATA: cell_char_q <= mem_rdata[7:0];
        tcw_pkg::S_GLYPH: begin
          // advance, wrap at row end, home after the last cell
          cnt_q <= cnt_q - 3'd1;
          if (col_last) begin
            col_q <= '0;
            if (row_last) begin
              row_q     <= '0;
              cleared_q <= 1'b1;
            end else begin
              row_q <= row_q + RW'(1);
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.out_column     <= 7'(col_q);
      out_data_q.out_row        <= 5'(row_q);
      out_data_q.cell_char      <= cell_char_q;
      out_data_q.screen_cleared <= cleared_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console cell writer, attached by bind.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int unsigned SCREEN_COLS = 80,
  parameter int unsigned SCREEN_ROWS = 25
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tcw_pkg::out_rsp_t out_data_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // reported column lies on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_column < SCREEN_COLS)
    else $error("column beyond screen width");

  // reported row lies on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_row < SCREEN_ROWS)
    else $error("row beyond screen height");

  // a clear result reports no cell character and leaves the cursor on the top row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.screen_cleared |->
      out_data_o.out_row == 5'd0 && out_data_o.cell_char == 8'd0)
    else $error("clear result with cursor off the top row");

endmodule

bind text_console_cell_writer tcw_checker #(
  .SCREEN_COLS(SCREEN_COLS),
  .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console cell writer. A cycle-free model of
// the screen, cursor and text color predicts the result of every accepted
// request; a monitor compares each result field by field. Directed requests
// cover the control characters, wrapping, clears and position reads. Random
// traffic then runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int unsigned COLS       = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLS * ROWS;
  localparam int unsigned PHASE_REQS = 500;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_req_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_rsp_t   out_data_o;

  // model of the screen and cursor
  logic [15:0] screen_mem [CELL_COUNT];
  int unsigned cursor_col;
  int unsigned cursor_row;
  logic [7:0]  text_attr;

  out_rsp_t    expected_rsps [$];
  int unsigned err_count     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;

  text_console_cell_writer #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // fill the screen with spaces and send the cursor home
  function automatic void clear_screen_model();
    int unsigned i;
    for (i = 0; i < CELL_COUNT; i++) screen_mem[i] = {text_attr, CH_SPACE};
    cursor_col = 0;
    cursor_row = 0;
  endfunction

  // store one character at the cursor and advance, returns 1 on a clear
  function automatic bit store_glyph(input logic [7:0] ch);
    screen_mem[cursor_row * COLS + cursor_col] = {text_attr, ch};
    cursor_col++;
    if (cursor_col >= COLS) begin
      cursor_col = 0;
      cursor_row++;
    end
    if (cursor_row >= ROWS) begin
      clear_screen_model();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // put request: control codes move the cursor, anything else is stored
  function automatic bit put_char(input logic [7:0] ch);
    bit          cleared;
    int unsigned n;
    int unsigned i;
    cleared = 1'b0;
    case (ch)
      CH_NUL: ;
      CH_NEWLINE: begin
        cursor_col = 0;
        cursor_row++;
        if (cursor_row >= ROWS) begin
          clear_screen_model();
          cleared = 1'b1;
        end
      end
      CH_RETURN: cursor_col = 0;
      CH_TAB: begin
        n = TAB_STOP - (cursor_col % TAB_STOP);
        for (i = 0; i < n; i++)
          if (store_glyph(CH_SPACE)) cleared = 1'b1;
      end
      default: cleared = store_glyph(ch);
    endcase
    return cleared;
  endfunction

  // expected result of one request, updates the model
  function automatic out_rsp_t predict_rsp(input in_req_t req);
    out_rsp_t rsp;
    rsp = '0;
    if (req.func == FUNC_PUT) begin
      rsp.screen_cleared = put_char(req.char_code);
    end else begin
      cursor_col    = req.target_col % COLS;
      cursor_row    = req.target_row % ROWS;
      rsp.cell_char = screen_mem[cursor_row * COLS + cursor_col][7:0];
    end
    rsp.out_column = 7'(cursor_col);
    rsp.out_row    = 5'(cursor_row);
    return rsp;
  endfunction

  function automatic in_req_t make_put(input logic [7:0] ch);
    in_req_t req;
    req.func       = FUNC_PUT;
    req.char_code  = ch;
    req.target_col = 8'($urandom_range(0, 255));
    req.target_row = 8'($urandom_range(0, 255));
    return req;
  endfunction

  function automatic in_req_t make_pos(input logic [7:0] col, input logic [7:0] row);
    in_req_t req;
    req.func       = FUNC_POS;
    req.char_code  = 8'($urandom_range(0, 255));
    req.target_col = col;
    req.target_row = row;
    return req;
  endfunction

  // random request, biased toward control characters and reads
  function automatic in_req_t random_req();
    in_req_t     req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    req  = make_put(8'($urandom_range(0, 255)));
    if (pick < 12) req = make_pos(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else if (pick < 22) req.char_code = CH_NEWLINE;
    else if (pick < 28) req.char_code = CH_TAB;
    else if (pick < 31) req.char_code = CH_RETURN;
    else if (pick < 33) req.char_code = CH_NUL;
    return req;
  endfunction

  // send one request, leaving valid high after acceptance
  task automatic send_req(input in_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_rsps.push_back(predict_rsp(req));
  endtask

  // drop valid and wait for every pending result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  // color write, block idle
  task automatic write_color(input logic [7:0] color);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= color;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    text_attr   = color;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
  end

  task automatic report_field(input string name, input int exp_val, input int got_val);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
    err_count++;
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: result with no request pending, got col %0d row %0d char %0d clr %0d",
                 $time, out_data_o.out_column, out_data_o.out_row, out_data_o.cell_char,
                 out_data_o.screen_cleared);
        err_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_data_o.out_column !== exp_rsp.out_column)
          report_field("out_column", exp_rsp.out_column, out_data_o.out_column);
        if (out_data_o.out_row !== exp_rsp.out_row)
          report_field("out_row", exp_rsp.out_row, out_data_o.out_row);
        if (out_data_o.cell_char !== exp_rsp.cell_char)
          report_field("cell_char", exp_rsp.cell_char, out_data_o.cell_char);
        if (out_data_o.screen_cleared !== exp_rsp.screen_cleared)
          report_field("screen_cleared", exp_rsp.screen_cleared, out_data_o.screen_cleared);
      end
    end
  end

  // reset, wait out the power-on sweep, read the blank screen
  task automatic test_reset_state();
    text_attr = RESET_COLOR;
    clear_screen_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    write_color(RESET_COLOR);
    send_req(make_pos(8'd0, 8'd0));
    send_req(make_pos(8'd79, 8'd24));
    wait_drained();
  endtask

  // control characters, wrapping, clears and position reads
  task automatic test_cursor_controls();
    send_req(make_pos(8'd0, 8'd0));
    send_req(make_put(8'h41));
    send_req(make_put(8'hff));
    send_req(make_put(CH_NUL));
    send_req(make_put(CH_RETURN));
    send_req(make_put(CH_TAB));
    send_req(make_put(8'h01));
    send_req(make_put(CH_TAB));
    send_req(make_put(CH_NEWLINE));
    send_req(make_pos(8'd255, 8'd255));
    send_req(make_pos(8'd4, 8'd0));
    send_req(make_pos(8'd80, 8'd25));
    // last cell then one character: wrap off the bottom
    send_req(make_pos(8'd79, 8'd24));
    send_req(make_put(8'h7e));
    // newline on the bottom row
    send_req(make_pos(8'd0, 8'd24));
    send_req(make_put(CH_NEWLINE));
    // tab running off the last row
    send_req(make_pos(8'd77, 8'd24));
    send_req(make_put(CH_TAB));
    send_req(make_pos(8'd128, 8'd127));
    send_req(make_put(8'h80));
    send_req(make_pos(8'd48, 8'd2));
    wait_drained();
  endtask

  // color extremes only touch later writes
  task automatic test_color_changes();
    write_color(8'hff);
    send_req(make_put(8'h5a));
    wait_drained();
    write_color(8'h00);
    send_req(make_put(8'h7a));
    send_req(make_pos(8'd1, 8'd0));
    wait_drained();
  endtask

  // random requests under each idling pattern
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
        default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
      endcase
      write_color(8'($urandom_range(0, 255)));
      for (n = 0; n < PHASE_REQS; n++) send_req(random_req());
      wait_drained();
    end
  endtask

  initial begin
    test_reset_state();
    test_cursor_controls();
    test_color_changes();
    test_random_traffic();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 600000);
    $display("tb: FAIL");
    $finish;
  end

endmodule
